[rtl/clock_chunk_cache_table_unit_macros.svh]
// ----------------------------------------------------------------------------
// Clock chunk cache table: assertion macros
// Concurrent assertion wrappers for the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef CLOCK_CHUNK_CACHE_TABLE_UNIT_MACROS_SVH
`define CLOCK_CHUNK_CACHE_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CCCT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccct: implication check failed");
`define CCCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccct: next-cycle check failed");
`define CCCT_ASSERT_ONEHOT0(label, clk, rst, vec) \
  label: assert property (@(posedge clk) disable iff (rst) $onehot0(vec)) \
    else $error("ccct: one-hot check failed");
`else
`define CCCT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CCCT_ASSERT_NEXT(label, clk, rst, ante, cons)
`define CCCT_ASSERT_ONEHOT0(label, clk, rst, vec)
`endif
`endif

[rtl/ccct_pkg.sv]
// ----------------------------------------------------------------------------
// Clock chunk cache table package
// Shared types, request and status codes for the clock replacement table.
// ----------------------------------------------------------------------------
package ccct_pkg;

  localparam int NUM_CHUNKS = 1024;
  localparam int ADDR_W     = 10;
  localparam int CNT_W      = ADDR_W + 1;
  localparam int VIS_W      = CNT_W + 1;

  localparam int REG_CHUNKS_IN_USE = 0;

  localparam logic [2:0] REQ_HIT     = 3'd0;
  localparam logic [2:0] REQ_ALLOC   = 3'd1;
  localparam logic [2:0] REQ_RELEASE = 3'd2;
  localparam logic [2:0] REQ_FETCH   = 3'd3;
  localparam logic [2:0] REQ_BACKEND = 3'd4;
  localparam logic [2:0] REQ_STORE   = 3'd5;

  localparam logic [1:0] ST_EMPTY    = 2'd0;
  localparam logic [1:0] ST_FETCHING = 2'd1;
  localparam logic [1:0] ST_FILLING  = 2'd2;
  localparam logic [1:0] ST_VALID    = 2'd3;

  localparam logic [2:0] OC_OK        = 3'd0;
  localparam logic [2:0] OC_NO_VICTIM = 3'd1;
  localparam logic [2:0] OC_UNDERFLOW = 3'd2;
  localparam logic [2:0] OC_HIT_EMPTY = 3'd3;
  localparam logic [2:0] OC_PIN_SAT   = 3'd4;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [ADDR_W-1:0] chunk_index;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_index;
    logic [1:0]        chunk_state;
    logic              victim_was_used;
    logic [2:0]        outcome;
  } out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SW_RD,
    S_SW_EV,
    S_GU_RD,
    S_GU_OUT
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic rd_hand;
    logic exec;
    logic sweep_adv;
    logic alloc_done;
    logic give_up;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic in_is_alloc;
    logic victim;
    logic exhausted;
    logic out_free;
  } sts_t;

endpackage

[rtl/ccct_ctrl.sv]
// ----------------------------------------------------------------------------
// Clock chunk cache table controller
// Sequences the clearing pass, single-entry requests and the clock sweep.
// ----------------------------------------------------------------------------
module ccct_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ccct_pkg::sts_t  sts,
  output ccct_pkg::cmd_t  cmd
);

  ccct_pkg::state_t state;
  ccct_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccct_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ccct_pkg::S_CLEAR: begin
        if (sts.clear_last) state_next = ccct_pkg::S_IDLE;
      end
      ccct_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = sts.in_is_alloc ? ccct_pkg::S_SW_RD : ccct_pkg::S_EXEC;
        end
      end
      ccct_pkg::S_EXEC: begin
        if (sts.out_free) state_next = ccct_pkg::S_IDLE;
      end
      ccct_pkg::S_SW_RD: begin
        state_next = ccct_pkg::S_SW_EV;
      end
      ccct_pkg::S_SW_EV: begin
        if (sts.victim) begin
          if (sts.out_free) state_next = ccct_pkg::S_IDLE;
        end else if (sts.exhausted) begin
          state_next = ccct_pkg::S_GU_RD;
        end else begin
          state_next = ccct_pkg::S_SW_RD;
        end
      end
      ccct_pkg::S_GU_RD: begin
        state_next = ccct_pkg::S_GU_OUT;
      end
      ccct_pkg::S_GU_OUT: begin
        if (sts.out_free) state_next = ccct_pkg::S_IDLE;
      end
      default: begin
        state_next = ccct_pkg::S_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state)
      ccct_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ccct_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ccct_pkg::S_EXEC: begin
        cmd.exec = sts.out_free;
      end
      ccct_pkg::S_SW_RD: begin
        cmd.rd_hand = 1'b1;
      end
      ccct_pkg::S_SW_EV: begin
        cmd.sweep_adv  = !sts.victim;
        cmd.alloc_done = sts.victim && sts.out_free;
      end
      ccct_pkg::S_GU_RD: begin
        cmd.rd_hand = 1'b1;
      end
      ccct_pkg::S_GU_OUT: begin
        cmd.give_up = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[rtl/ccct_datapath.sv]
// ----------------------------------------------------------------------------
// Clock chunk cache table datapath
// Entry memory, clock hand, sweep counters and the result register.
// ----------------------------------------------------------------------------
module ccct_datapath #(
  parameter int PIN_WIDTH = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ccct_pkg::in_t                  in_data,
  input  logic [ccct_pkg::CNT_W-1:0]     chunks_in_use,
  input  ccct_pkg::cmd_t                 cmd,
  output ccct_pkg::sts_t                 sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ccct_pkg::out_t                 out_data
);

  localparam int ENTRY_W = PIN_WIDTH + 3;
  localparam int AW      = ccct_pkg::ADDR_W;
  localparam int CW      = ccct_pkg::CNT_W;
  localparam int VW      = ccct_pkg::VIS_W;

  logic [ENTRY_W-1:0]   mem [ccct_pkg::NUM_CHUNKS];
  logic [ENTRY_W-1:0]   rd_data;
  logic [ENTRY_W-1:0]   wr_data;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic                 rd_en;
  logic                 wr_en;

  logic [2:0]           req_type;
  logic [AW-1:0]        req_idx;
  logic [AW-1:0]        hand;
  logic [AW-1:0]        hand_adv;
  logic [CW-1:0]        hand_inc;
  logic [VW-1:0]        visits;
  logic [AW-1:0]        clr_addr;
  logic [CW-1:0]        n_active;

  logic [1:0]           rd_status;
  logic [PIN_WIDTH-1:0] rd_pin;
  logic                 rd_acc;
  logic                 pin_full;
  logic                 pin_zero;
  logic [PIN_WIDTH-1:0] pin_inc;
  logic [PIN_WIDTH-1:0] pin_dec;

  logic [1:0]           ex_status;
  logic [PIN_WIDTH-1:0] ex_pin;
  logic                 ex_acc;
  logic [2:0]           ex_outcome;

  always_comb begin
    if (chunks_in_use == '0) begin
      n_active = CW'(1);
    end else if (chunks_in_use > CW'(ccct_pkg::NUM_CHUNKS)) begin
      n_active = CW'(ccct_pkg::NUM_CHUNKS);
    end else begin
      n_active = chunks_in_use;
    end
  end

  assign rd_status = rd_data[ENTRY_W-1 -: 2];
  assign rd_pin    = rd_data[PIN_WIDTH:1];
  assign rd_acc    = rd_data[0];
  assign pin_full  = (rd_pin == {PIN_WIDTH{1'b1}});
  assign pin_zero  = (rd_pin == '0);
  assign pin_inc   = pin_full ? rd_pin : rd_pin + PIN_WIDTH'(1);
  assign pin_dec   = pin_zero ? rd_pin : rd_pin - PIN_WIDTH'(1);

  assign hand_inc  = {1'b0, hand} + CW'(1);
  assign hand_adv  = (hand_inc == n_active) ? '0 : hand_inc[AW-1:0];

  always_comb begin
    ex_status  = rd_status;
    ex_pin     = rd_pin;
    ex_acc     = rd_acc;
    ex_outcome = ccct_pkg::OC_OK;
    case (req_type)
      ccct_pkg::REQ_HIT: begin
        if (rd_status == ccct_pkg::ST_EMPTY) begin
          ex_outcome = ccct_pkg::OC_HIT_EMPTY;
        end else begin
          ex_acc     = 1'b1;
          ex_pin     = pin_inc;
          ex_outcome = pin_full ? ccct_pkg::OC_PIN_SAT : ccct_pkg::OC_OK;
        end
      end
      ccct_pkg::REQ_RELEASE: begin
        ex_pin     = pin_dec;
        ex_outcome = pin_zero ? ccct_pkg::OC_UNDERFLOW : ccct_pkg::OC_OK;
      end
      ccct_pkg::REQ_FETCH: begin
        ex_status = ccct_pkg::ST_FETCHING;
      end
      ccct_pkg::REQ_BACKEND: begin
        ex_status = ccct_pkg::ST_FILLING;
      end
      ccct_pkg::REQ_STORE: begin
        ex_status  = ccct_pkg::ST_VALID;
        ex_pin     = pin_dec;
        ex_outcome = pin_zero ? ccct_pkg::OC_UNDERFLOW : ccct_pkg::OC_OK;
      end
      default: begin
        ex_status = rd_status;
      end
    endcase
  end

  always_comb begin
    rd_en   = cmd.accept || cmd.rd_hand;
    rd_addr = cmd.accept ? in_data.chunk_index : hand;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hand;
    wr_data = rd_data;
    if (cmd.clear_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (cmd.exec) begin
      wr_en   = 1'b1;
      wr_addr = req_idx;
      wr_data = {ex_status, ex_pin, ex_acc};
    end else if (cmd.sweep_adv) begin
      wr_en   = 1'b1;
      wr_data = {rd_status, rd_pin, rd_acc && !pin_zero};
    end else if (cmd.alloc_done) begin
      wr_en   = 1'b1;
      wr_data = {ccct_pkg::ST_EMPTY, pin_inc, rd_acc};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type <= in_data.req_type;
      req_idx  <= in_data.chunk_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      hand     <= '0;
      visits   <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.accept) begin
        visits <= '0;
        if (sts.in_is_alloc && ({1'b0, hand} >= n_active)) begin
          hand <= '0;
        end
      end else if (cmd.sweep_adv) begin
        visits <= visits + VW'(1);
        hand   <= hand_adv;
      end else if (cmd.alloc_done) begin
        hand <= hand_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec || cmd.alloc_done || cmd.give_up) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data.result_index    <= req_idx;
      out_data.chunk_state     <= ex_status;
      out_data.victim_was_used <= 1'b0;
      out_data.outcome         <= ex_outcome;
    end else if (cmd.alloc_done) begin
      out_data.result_index    <= hand;
      out_data.chunk_state     <= ccct_pkg::ST_EMPTY;
      out_data.victim_was_used <= (rd_status != ccct_pkg::ST_EMPTY);
      out_data.outcome         <= pin_full ? ccct_pkg::OC_PIN_SAT : ccct_pkg::OC_OK;
    end else if (cmd.give_up) begin
      out_data.result_index    <= hand;
      out_data.chunk_state     <= rd_status;
      out_data.victim_was_used <= 1'b0;
      out_data.outcome         <= ccct_pkg::OC_NO_VICTIM;
    end
  end

  assign sts.clear_last  = (clr_addr == AW'(ccct_pkg::NUM_CHUNKS - 1));
  assign sts.in_is_alloc = (in_data.req_type == ccct_pkg::REQ_ALLOC);
  assign sts.victim      = (rd_status == ccct_pkg::ST_EMPTY) || (pin_zero && !rd_acc);
  assign sts.exhausted   = ((visits + VW'(1)) == {n_active, 1'b0});
  assign sts.out_free    = !out_valid || out_ready;

endmodule

[rtl/clock_chunk_cache_table_unit.sv]
// ----------------------------------------------------------------------------
// Clock chunk cache table unit
// Chunk entry table with second-chance victim selection over a clock hand.
//
// Requests enter on in_valid/in_ready and each gives one result on
// out_valid/out_ready. A request is taken only while the block is idle.
// Hit, release, fetch start, backend done and store done read one entry of
// the table memory and write it back, and the result is registered together
// with the write-back. An allocate moves the hand over the entries one at a
// time, and each visit is a memory read followed by a write-back; when no
// victim turns up after two passes over the active entries it gives up
// with a no-victim result. The result register frees the table for the
// next request while a result still waits; a request finishes only once
// that register can take its result, so a stalled receiver holds the
// block in that state.
// After reset the table is cleared by a pass over all 1024 entries, one
// entry per cycle, during which in_ready stays low; configuration writes
// are taken throughout. The chunks_in_use register sits at byte address 0.
// ----------------------------------------------------------------------------
`include "clock_chunk_cache_table_unit_macros.svh"

module clock_chunk_cache_table_unit #(
  parameter int PIN_WIDTH = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ccct_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ccct_pkg::out_t  out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  logic [ccct_pkg::CNT_W-1:0] chunks_in_use;
  logic                       reg_sel;
  ccct_pkg::cmd_t             cmd;
  ccct_pkg::sts_t             sts;
  logic                       load_out;
  logic [3:0]                 wr_cmds;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2:2] == 1'(ccct_pkg::REG_CHUNKS_IN_USE));

  always_ff @(posedge clk) begin
    if (rst) begin
      chunks_in_use <= ccct_pkg::CNT_W'(ccct_pkg::NUM_CHUNKS);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      chunks_in_use <= pwdata[ccct_pkg::CNT_W-1:0];
    end
  end

  assign prdata = reg_sel ? 32'(chunks_in_use) : '0;

  ccct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ccct_datapath #(
    .PIN_WIDTH (PIN_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .in_data       (in_data),
    .chunks_in_use (chunks_in_use),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

  assign load_out = cmd.exec || cmd.alloc_done || cmd.give_up;
  assign wr_cmds  = {cmd.clear_step, cmd.exec, cmd.sweep_adv, cmd.alloc_done};

  `CCCT_ASSERT_IMPL(a_no_accept_in_clear, clk, rst, in_ready, !cmd.clear_step)
  `CCCT_ASSERT_IMPL(a_load_when_free, clk, rst, load_out, sts.out_free)
  `CCCT_ASSERT_ONEHOT0(a_single_writer, clk, rst, wr_cmds)
  `CCCT_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

endmodule

[dv/chunk_table_tracker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chunk table tracker
// Watches the request, result and register ports of the clock chunk cache
// table, keeps its own copy of the entry table and clock hand, and compares
// every result with the one predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module chunk_table_tracker #(
  parameter int PIN_WIDTH = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  ccct_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  ccct_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  input  logic           pready,
  output int             mismatch_count,
  output int             results_awaited
);

  localparam logic [PIN_WIDTH-1:0] PIN_LIMIT = {PIN_WIDTH{1'b1}};

  logic [1:0]           status_mem [ccct_pkg::NUM_CHUNKS];
  logic [PIN_WIDTH-1:0] pin_mem [ccct_pkg::NUM_CHUNKS];
  logic                 accessed_mem [ccct_pkg::NUM_CHUNKS];
  int                   hand;
  logic [10:0]          chunks_cfg;
  ccct_pkg::out_t       expected_results [$];
  ccct_pkg::out_t       want;

  function automatic logic [2:0] pin_inc(int e);
    if (pin_mem[e] == PIN_LIMIT) return ccct_pkg::OC_PIN_SAT;
    pin_mem[e] = pin_mem[e] + 1'b1;
    return ccct_pkg::OC_OK;
  endfunction

  function automatic logic [2:0] pin_dec(int e);
    if (pin_mem[e] == '0) return ccct_pkg::OC_UNDERFLOW;
    pin_mem[e] = pin_mem[e] - 1'b1;
    return ccct_pkg::OC_OK;
  endfunction

  function automatic ccct_pkg::out_t clock_table_apply(ccct_pkg::in_t rq);
    ccct_pkg::out_t res;
    int             span;
    int             visits;
    int             idx;
    logic [2:0]     oc;
    logic           used;
    logic           found;
    idx   = int'(rq.chunk_index) % ccct_pkg::NUM_CHUNKS;
    oc    = ccct_pkg::OC_OK;
    used  = 1'b0;
    found = 1'b0;
    span  = int'(chunks_cfg);
    if (span == 0) span = 1;
    if (span > ccct_pkg::NUM_CHUNKS) span = ccct_pkg::NUM_CHUNKS;
    case (rq.req_type)
      ccct_pkg::REQ_HIT: begin
        if (status_mem[idx] == ccct_pkg::ST_EMPTY) begin
          oc = ccct_pkg::OC_HIT_EMPTY;
        end else begin
          oc = pin_inc(idx);
          accessed_mem[idx] = 1'b1;
        end
      end
      ccct_pkg::REQ_ALLOC: begin
        if (hand >= span) hand = 0;
        visits = 0;
        while (!found && visits < 2 * span) begin
          if (status_mem[hand] == ccct_pkg::ST_EMPTY ||
              (pin_mem[hand] == '0 && !accessed_mem[hand])) begin
            found = 1'b1;
          end else begin
            if (pin_mem[hand] == '0) accessed_mem[hand] = 1'b0;
            hand = (hand + 1) % span;
            visits++;
          end
        end
        idx = hand;
        if (!found) begin
          oc = ccct_pkg::OC_NO_VICTIM;
        end else begin
          used = (status_mem[idx] != ccct_pkg::ST_EMPTY);
          status_mem[idx] = ccct_pkg::ST_EMPTY;
          oc = pin_inc(idx);
          hand = (idx + 1) % span;
        end
      end
      ccct_pkg::REQ_RELEASE: oc = pin_dec(idx);
      ccct_pkg::REQ_FETCH:   status_mem[idx] = ccct_pkg::ST_FETCHING;
      ccct_pkg::REQ_BACKEND: status_mem[idx] = ccct_pkg::ST_FILLING;
      ccct_pkg::REQ_STORE: begin
        status_mem[idx] = ccct_pkg::ST_VALID;
        oc = pin_dec(idx);
      end
      default: ;
    endcase
    res.result_index    = idx[ccct_pkg::ADDR_W-1:0];
    res.chunk_state     = status_mem[idx];
    res.victim_was_used = used;
    res.outcome         = oc;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ccct_pkg::NUM_CHUNKS; k++) begin
        status_mem[k]   = ccct_pkg::ST_EMPTY;
        pin_mem[k]      = '0;
        accessed_mem[k] = 1'b0;
      end
      hand       = 0;
      chunks_cfg = 11'(ccct_pkg::NUM_CHUNKS);
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr == 3'(ccct_pkg::REG_CHUNKS_IN_USE * 4)) begin
        chunks_cfg = pwdata[10:0];
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("Result %p arrived with no request outstanding.", out_data);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.result_index !== want.result_index) begin
            $error("result_index: expected %0d, got %0d",
                   want.result_index, out_data.result_index);
            mismatch_count++;
          end
          if (out_data.chunk_state !== want.chunk_state) begin
            $error("chunk_state: expected %0d, got %0d",
                   want.chunk_state, out_data.chunk_state);
            mismatch_count++;
          end
          if (out_data.victim_was_used !== want.victim_was_used) begin
            $error("victim_was_used: expected %0d, got %0d",
                   want.victim_was_used, out_data.victim_was_used);
            mismatch_count++;
          end
          if (out_data.outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, out_data.outcome);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(), clock_table_apply(in_data));
      end
    end
    results_awaited = expected_results.size();
  end

endmodule

[dv/clock_chunk_cache_table_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Clock chunk cache table testbench
// Drives requests and register writes into the clock chunk cache table with
// bursty sender and a stalling receiver, over several table sizes, and
// reports the verdict from the tracker's mismatch count.
// ----------------------------------------------------------------------------
module clock_chunk_cache_table_unit_test;

  localparam int         PIN_WIDTH   = 8;
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  logic           clk = 1'b0;
  logic           rst;
  logic           in_valid;
  logic           in_ready;
  ccct_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  ccct_pkg::out_t out_data;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [2:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;
  int             mismatch_count;
  int             results_awaited;
  int             burst_left;
  bit             sender_gaps;
  int             hold_asked;
  int             hold_served;

  clock_chunk_cache_table_unit #(.PIN_WIDTH(PIN_WIDTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  chunk_table_tracker #(.PIN_WIDTH(PIN_WIDTH)) tracker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatch_count(mismatch_count), .results_awaited(results_awaited)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int mode;
    int left;
    int hold;
    out_ready = 1'b0;
    hold_served = 0;
    mode = 0;
    left = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_asked) begin
        hold = 400;
        hold_served = hold_asked;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(40, 160);
      end
      left--;
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 6) != 0);
          default: out_ready <= (left % 5 != 0);
        endcase
      end
    end
  end

  task automatic send_req(logic [2:0] kind, logic [ccct_pkg::ADDR_W-1:0] entry);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (sender_gaps && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {kind, entry};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (results_awaited != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic cfg_write(logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(ccct_pkg::REG_CHUNKS_IN_USE * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_requests(int count, int span, int hit_w, int focus_pct);
    logic [2:0]                  kind;
    logic [ccct_pkg::ADDR_W-1:0] entry;
    int                          pick;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < hit_w) begin
        kind = ccct_pkg::REQ_HIT;
      end else begin
        pick = $urandom_range(0, 15);
        if (pick < 5) kind = ccct_pkg::REQ_ALLOC;
        else if (pick < 8) kind = ccct_pkg::REQ_RELEASE;
        else if (pick < 10) kind = ccct_pkg::REQ_FETCH;
        else if (pick < 12) kind = ccct_pkg::REQ_BACKEND;
        else if (pick < 15) kind = ccct_pkg::REQ_STORE;
        else kind = $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
      end
      if ($urandom_range(0, 15) == 0) begin
        entry = ccct_pkg::ADDR_W'($urandom_range(0, ccct_pkg::NUM_CHUNKS - 1));
      end else if ($urandom_range(0, 99) < focus_pct) begin
        entry = '0;
      end else begin
        entry = ccct_pkg::ADDR_W'($urandom_range(0, span - 1));
      end
      send_req(kind, entry);
    end
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    burst_left  = 0;
    sender_gaps = 1'b1;
    hold_asked  = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    cfg_write(32'd4);
    send_req(ccct_pkg::REQ_HIT, 10'd0);
    send_req(ccct_pkg::REQ_RELEASE, 10'd0);
    send_req(ccct_pkg::REQ_STORE, 10'd0);
    send_req(ccct_pkg::REQ_HIT, 10'd0);
    send_req(ccct_pkg::REQ_ALLOC, 10'd1023);
    send_req(ccct_pkg::REQ_FETCH, 10'd1);
    send_req(ccct_pkg::REQ_BACKEND, 10'd1);
    send_req(ccct_pkg::REQ_STORE, 10'd1);
    send_req(ccct_pkg::REQ_ALLOC, 10'd0);
    send_req(ccct_pkg::REQ_RELEASE, 10'd0);
    send_req(ccct_pkg::REQ_ALLOC, 10'd0);
    send_req(ccct_pkg::REQ_HIT, 10'd1023);
    send_req(ccct_pkg::REQ_FETCH, 10'd1023);
    send_req(ccct_pkg::REQ_HIT, 10'd1023);
    send_req(REQ_SPARE_LO, 10'd1023);
    send_req(REQ_SPARE_HI, 10'd0);
    settle();
    cfg_write(32'd1);
    send_req(ccct_pkg::REQ_ALLOC, 10'd0);
    send_req(ccct_pkg::REQ_FETCH, 10'd0);
    send_req(ccct_pkg::REQ_ALLOC, 10'd0);
    send_req(ccct_pkg::REQ_STORE, 10'd0);
    send_req(ccct_pkg::REQ_RELEASE, 10'd0);
    settle();

    cfg_write(32'd8);
    hold_asked++;
    random_requests(150, 8, 35, 15);
    settle();
    random_requests(200, 8, 35, 15);
    settle();

    cfg_write(32'd2);
    random_requests(500, 2, 80, 70);
    settle();

    sender_gaps = 1'b0;
    cfg_write(32'd1024);
    random_requests(80, 1024, 30, 10);
    settle();

    sender_gaps = 1'b1;
    cfg_write(32'd0);
    random_requests(60, 4, 30, 20);
    settle();

    sender_gaps = 1'b0;
    cfg_write(32'hFFFF_FFFF);
    random_requests(60, 1024, 30, 10);
    settle();

    cfg_write(32'd16);
    random_requests(200, 16, 40, 25);
    sender_gaps = 1'b1;
    random_requests(250, 16, 40, 25);
    settle();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
